@@ design/qrmm_pkg.sv @@
// Shared types, constants and helper functions for the quad rate loop motor mixer.
`default_nettype none

package qrmm_pkg;

    // Stream word widths, padded to whole bytes.
    localparam int IN_W  = 176;
    localparam int OUT_W = 72;

    // Pipeline depth from input register to output register.
    localparam int NSTAGE = 8;

    // Configuration port widths.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Reset values of the configuration registers.
    localparam logic [15:0] ANGLE_GAIN_RST    = 16'd3355;
    localparam logic [15:0] RATE_GAIN_RST     = 16'd3932;
    localparam logic [15:0] YAW_RATE_GAIN_RST = 16'd655;
    localparam logic [7:0]  STABILITY_RST     = 8'd50;

    // Limits of the control law.
    localparam logic signed [25:0] YAW_LIMIT  = 26'sd500000;
    localparam logic signed [19:0] TERM_LIMIT = 20'sd30000;
    localparam logic [7:0]         MOTOR_MAX  = 8'd160;
    localparam logic [7:0]         MOTOR_MIN  = 8'd20;
    localparam logic [7:0]         THR_MAX    = 8'd135;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ANGLE_GAIN    = 2'd0,
        CFG_RATE_GAIN     = 2'd1,
        CFG_YAW_RATE_GAIN = 2'd2,
        CFG_STABILITY     = 2'd3
    } t_cfg_idx;

    // Values that ride along the pipeline; each stage fills in its own fields.
    typedef struct packed {
        logic signed [13:0] ps;
        logic signed [13:0] rs;
        logic        [7:0]  thr;
        logic signed [12:0] setp;
        logic signed [19:0] yaw;
        logic signed [15:0] tp;
        logic signed [15:0] tr;
        logic signed [15:0] ty;
        logic signed [7:0]  g;
        logic        [9:0]  bound;
    } t_ctx;

    // Saturate a correction term to the symmetric term limit.
    function automatic logic signed [15:0] sat_term(input logic signed [19:0] v);
        logic signed [19:0] r;
        begin
            if (v > TERM_LIMIT) begin
                r = TERM_LIMIT;
            end else if (v < -TERM_LIMIT) begin
                r = -TERM_LIMIT;
            end else begin
                r = v;
            end
            return r[15:0];
        end
    endfunction

    // Clamp a raw motor sum into the allowed drive range.
    function automatic logic [7:0] clamp_motor(input logic signed [12:0] v);
        logic [7:0] r;
        begin
            if (v > $signed({5'd0, MOTOR_MAX})) begin
                r = MOTOR_MAX;
            end else if (v < $signed({5'd0, MOTOR_MIN})) begin
                r = MOTOR_MIN;
            end else begin
                r = v[7:0];
            end
            return r;
        end
    endfunction

endpackage

`default_nettype wire

@@ design/quad_rate_loop_motor_mixer_unit.sv @@
// Top level of the quad rate loop motor mixer: an eight-stage control pipeline.
//
// Usage:
//   One input word per control tick carries the sticks, the throttle, the three
//   angle integrals and the three gyro rates. One output word per tick carries
//   the four X-mixed motor drives (20..160), the clamped yaw integral and the
//   expo-shaped yaw setpoint. Gains and the stability factor are written over a
//   plain write port (enable, index, data) while no word is in flight.
//   An accepted word passes through the eight register stages in order, from
//   stage 1 to stage 8, and is valid at the output once it reaches stage 8.
//   Throughput is one word per cycle while the receiver is ready, since every
//   stage can load in every cycle; the eight register stages, each one layer
//   of multipliers or of wide adds and compares, keep the clock period short.
//   Every stage keeps its own valid bit and loads whenever it is empty or the
//   stage after it moves, so bubbles close up and a stalled receiver only holds
//   the words already in the pipe; the input stays ready until every stage is
//   full. No word is lost or repeated across a stall.
//   Reset empties the pipeline and restores the default gains (angle 3355 in
//   Q0.24, rate 3932 and yaw rate 655 in Q0.16, stability 50).
`default_nettype none

module quad_rate_loop_motor_mixer_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // Input word, low bit up: yaw_stick[9:0], pitch_stick[23:10],
    // roll_stick[37:24], throttle[45:38], pitch_angle[70:46],
    // roll_angle[95:71], yaw_angle_in[120:96], pitch_rate[136:121],
    // roll_rate[152:137], yaw_rate[168:153], zero fill[175:169].
    input  wire logic [qrmm_pkg::IN_W-1:0]     i_s_tdata,
    input  wire logic                          i_s_tvalid,
    output logic                               o_s_tready,
    // Output word, low bit up: motor_front[7:0], motor_second[15:8],
    // motor_third[23:16], motor_fourth[31:24], yaw_angle_out[51:32],
    // yaw_setpoint[64:52], zero fill[71:65].
    output logic [qrmm_pkg::OUT_W-1:0]         o_m_tdata,
    output logic                               o_m_tvalid,
    input  wire logic                          i_m_tready,
    // Configuration write port.
    input  wire logic                          i_cfg_we,
    input  wire logic [qrmm_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [qrmm_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    import qrmm_pkg::*;

    // Configuration registers.
    logic [15:0] r_ka, r_kr, r_ky;
    logic [7:0]  r_stab;

    // Pipeline control.
    logic [NSTAGE:1] r_vld;
    logic [NSTAGE:1] w_rdy;
    logic [NSTAGE:1] w_vin;
    logic [NSTAGE:1] w_ld;

    // Stage registers.
    t_ctx r_s1, r_s2, r_s3, r_s4, r_s5, r_s6, r_s7;
    t_ctx n_s1, n_s2, n_s3, n_s4, n_s5, n_s6, n_s7;
    logic signed [41:0] r_s1_pa_ka, r_s1_ra_ka, n_s1_pa_ka, n_s1_ra_ka;
    logic signed [32:0] r_s1_pr_kr, r_s1_rr_kr, n_s1_pr_kr, n_s1_rr_kr;
    logic signed [32:0] r_s1_yr_ky, r_s2_yr_ky, r_s3_yr_ky, n_s1_yr_ky;
    logic signed [24:0] r_s1_ya, n_s1_ya;
    logic signed [36:0] r_s3_yaw_ka, n_s3_yaw_ka;
    logic signed [10:0] r_s7_dp, r_s7_dr, n_s7_dp, n_s7_dr;
    logic [7:0]         r_s8_m0, r_s8_m1, r_s8_m2, r_s8_m3;
    logic [7:0]         n_s8_m0, n_s8_m1, n_s8_m2, n_s8_m3;
    logic signed [19:0] r_s8_yaw;
    logic signed [12:0] r_s8_setp;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ka   <= ANGLE_GAIN_RST;
            r_kr   <= RATE_GAIN_RST;
            r_ky   <= YAW_RATE_GAIN_RST;
            r_stab <= STABILITY_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_ANGLE_GAIN:    r_ka   <= i_cfg_data;
                CFG_RATE_GAIN:     r_kr   <= i_cfg_data;
                CFG_YAW_RATE_GAIN: r_ky   <= i_cfg_data;
                CFG_STABILITY:     r_stab <= i_cfg_data[7:0];
                default:           r_stab <= r_stab;
            endcase
        end
    end

    // Ready ripples back from the output; a stage loads when empty or draining.
    always_comb begin
        w_rdy[NSTAGE] = !r_vld[NSTAGE] || i_m_tready;
        for (int k = NSTAGE - 1; k >= 1; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
    end

    assign w_vin = {r_vld[NSTAGE-1:1], i_s_tvalid};
    assign w_ld  = w_rdy & w_vin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 1; k <= NSTAGE; k++) begin
                if (w_rdy[k]) begin
                    r_vld[k] <= w_vin[k];
                end
            end
        end
    end

    assign o_s_tready = w_rdy[1];

    // Stage 1: unpack, throttle clamp, expo setpoint and the gain products.
    logic signed [9:0]  s1_ys;
    logic        [9:0]  s1_ys_abs;
    logic signed [20:0] s1_sq;
    logic signed [22:0] s1_e6, s1_e6b;
    logic signed [12:0] s1_y6, s1_y6b;
    logic signed [13:0] s1_setp;
    logic        [7:0]  s1_thr;

    always_comb begin
        s1_ys     = $signed(i_s_tdata[9:0]);
        s1_ys_abs = s1_ys[9] ? 10'(-s1_ys) : s1_ys;
        s1_sq     = s1_ys * $signed({1'b0, s1_ys_abs});
        s1_e6     = $signed({s1_sq, 2'b00}) + $signed({s1_sq[20], s1_sq, 1'b0});
        s1_e6b    = s1_e6 + (s1_e6[22] ? 23'sd511 : 23'sd0);
        s1_y6     = $signed({s1_ys[9], s1_ys, 2'b00})
                  + $signed({s1_ys[9], s1_ys[9], s1_ys, 1'b0});
        s1_y6b    = s1_y6 + (s1_y6[12] ? 13'sd3 : 13'sd0);
        s1_setp   = $signed(s1_e6b[22:9]) + $signed(s1_y6b[12:2]);
        s1_thr    = i_s_tdata[45:38];

        n_s1       = '0;
        n_s1.ps    = $signed(i_s_tdata[23:10]);
        n_s1.rs    = $signed(i_s_tdata[37:24]);
        n_s1.thr   = (s1_thr > THR_MAX) ? THR_MAX : s1_thr;
        n_s1.setp  = s1_setp[12:0];
        n_s1_pa_ka = $signed(i_s_tdata[70:46]) * $signed({1'b0, r_ka});
        n_s1_ra_ka = $signed(i_s_tdata[95:71]) * $signed({1'b0, r_ka});
        n_s1_pr_kr = $signed(i_s_tdata[136:121]) * $signed({1'b0, r_kr});
        n_s1_rr_kr = $signed(i_s_tdata[152:137]) * $signed({1'b0, r_kr});
        n_s1_yr_ky = $signed(i_s_tdata[168:153]) * $signed({1'b0, r_ky});
        n_s1_ya    = $signed(i_s_tdata[120:96]);
    end

    // Stage 2: pitch and roll terms, yaw integral update and clamp.
    logic signed [42:0] s2_tp_sum, s2_tr_sum, s2_tp_b, s2_tr_b;
    logic signed [25:0] s2_yaw;

    always_comb begin
        s2_tp_sum = r_s1_pa_ka + $signed({r_s1_pr_kr, 8'd0});
        s2_tr_sum = r_s1_ra_ka + $signed({r_s1_rr_kr, 8'd0});
        s2_tp_b   = s2_tp_sum + (s2_tp_sum[42] ? 43'sd16777215 : 43'sd0);
        s2_tr_b   = s2_tr_sum + (s2_tr_sum[42] ? 43'sd16777215 : 43'sd0);
        s2_yaw    = r_s1_ya - r_s1.setp;

        n_s2    = r_s1;
        n_s2.tp = sat_term(20'($signed(s2_tp_b[42:24])));
        n_s2.tr = sat_term(20'($signed(s2_tr_b[42:24])));
        if (s2_yaw > YAW_LIMIT) begin
            n_s2.yaw = YAW_LIMIT[19:0];
        end else if (s2_yaw < -YAW_LIMIT) begin
            n_s2.yaw = 20'(-YAW_LIMIT);
        end else begin
            n_s2.yaw = s2_yaw[19:0];
        end
    end

    // Stage 3: yaw integral times the angle gain.
    always_comb begin
        n_s3        = r_s2;
        n_s3_yaw_ka = r_s2.yaw * $signed({1'b0, r_ka});
    end

    // Stage 4: yaw term from rate and integral contributions.
    logic signed [43:0] s4_ty_sum, s4_ty_b;

    always_comb begin
        s4_ty_sum = $signed({r_s3_yr_ky, 10'd0}) + r_s3_yaw_ka;
        s4_ty_b   = s4_ty_sum + (s4_ty_sum[43] ? 44'sd67108863 : 44'sd0);
        n_s4      = r_s3;
        n_s4.ty   = sat_term(20'($signed(s4_ty_b[43:26])));
    end

    // Stage 5: yaw mix limited by half throttle and by headroom, zero below the motor minimum.
    logic signed [16:0] s5_g0, s5_g1, s5_g2, s5_lh, s5_lr;

    always_comb begin
        s5_g0 = r_s4.ty - r_s4.setp;
        s5_lh = $signed({10'd0, r_s4.thr[7:1]});
        s5_lr = $signed({9'd0, 8'(MOTOR_MAX - r_s4.thr)});
        if (s5_g0 > s5_lh) begin
            s5_g1 = s5_lh;
        end else if (s5_g0 < -s5_lh) begin
            s5_g1 = -s5_lh;
        end else begin
            s5_g1 = s5_g0;
        end
        if (s5_g1 > s5_lr) begin
            s5_g2 = s5_lr;
        end else if (s5_g1 < -s5_lr) begin
            s5_g2 = -s5_lr;
        end else begin
            s5_g2 = s5_g1;
        end
        n_s5   = r_s4;
        n_s5.g = (r_s4.thr < MOTOR_MIN) ? 8'sd0 : s5_g2[7:0];
    end

    // Stage 6: pitch and roll bound scaled by the stability factor.
    logic [7:0]  s6_ag;
    logic [8:0]  s6_sum;
    logic [16:0] s6_prod;

    always_comb begin
        s6_ag      = r_s5.g[7] ? 8'(-r_s5.g) : r_s5.g;
        s6_sum     = {1'b0, r_s5.thr} + {2'd0, s6_ag[7:1]};
        s6_prod    = r_stab * s6_sum;
        n_s6       = r_s5;
        n_s6.bound = s6_prod[15:6];
    end

    // Stage 7: pitch and roll corrections clamped to the bound.
    logic signed [17:0] s7_ep, s7_er, s7_b;

    always_comb begin
        s7_ep = r_s6.tp - r_s6.ps;
        s7_er = r_s6.tr - r_s6.rs;
        s7_b  = $signed({8'd0, r_s6.bound});
        if (s7_ep > s7_b) begin
            n_s7_dp = s7_b[10:0];
        end else if (s7_ep < -s7_b) begin
            n_s7_dp = 11'(-s7_b);
        end else begin
            n_s7_dp = s7_ep[10:0];
        end
        if (s7_er > s7_b) begin
            n_s7_dr = s7_b[10:0];
        end else if (s7_er < -s7_b) begin
            n_s7_dr = 11'(-s7_b);
        end else begin
            n_s7_dr = s7_er[10:0];
        end
        n_s7 = r_s6;
    end

    // Stage 8: X mixing and motor clamp.
    logic signed [12:0] s8_t;

    always_comb begin
        s8_t    = $signed({5'd0, r_s7.thr});
        n_s8_m0 = clamp_motor(s8_t + r_s7_dp - r_s7.g - r_s7_dr);
        n_s8_m1 = clamp_motor(s8_t + r_s7_dp + r_s7.g + r_s7_dr);
        n_s8_m2 = clamp_motor(s8_t - r_s7_dp + r_s7.g - r_s7_dr);
        n_s8_m3 = clamp_motor(s8_t - r_s7_dp - r_s7.g + r_s7_dr);
    end

    // Payload registers load with their stage's valid bit.
    always_ff @(posedge i_clk) begin
        if (w_ld[1]) begin
            r_s1       <= n_s1;
            r_s1_pa_ka <= n_s1_pa_ka;
            r_s1_ra_ka <= n_s1_ra_ka;
            r_s1_pr_kr <= n_s1_pr_kr;
            r_s1_rr_kr <= n_s1_rr_kr;
            r_s1_yr_ky <= n_s1_yr_ky;
            r_s1_ya    <= n_s1_ya;
        end
        if (w_ld[2]) begin
            r_s2       <= n_s2;
            r_s2_yr_ky <= r_s1_yr_ky;
        end
        if (w_ld[3]) begin
            r_s3        <= n_s3;
            r_s3_yr_ky  <= r_s2_yr_ky;
            r_s3_yaw_ka <= n_s3_yaw_ka;
        end
        if (w_ld[4]) begin
            r_s4 <= n_s4;
        end
        if (w_ld[5]) begin
            r_s5 <= n_s5;
        end
        if (w_ld[6]) begin
            r_s6 <= n_s6;
        end
        if (w_ld[7]) begin
            r_s7    <= n_s7;
            r_s7_dp <= n_s7_dp;
            r_s7_dr <= n_s7_dr;
        end
        if (w_ld[8]) begin
            r_s8_m0   <= n_s8_m0;
            r_s8_m1   <= n_s8_m1;
            r_s8_m2   <= n_s8_m2;
            r_s8_m3   <= n_s8_m3;
            r_s8_yaw  <= r_s7.yaw;
            r_s8_setp <= r_s7.setp;
        end
    end

    // Output word.
    assign o_m_tvalid = r_vld[NSTAGE];
    assign o_m_tdata  = {7'd0, r_s8_setp, r_s8_yaw, r_s8_m3, r_s8_m2, r_s8_m1, r_s8_m0};

`ifndef SYNTHESIS
    // Motor drives leave the block inside the allowed range.
    a_motor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (r_s8_m0 >= MOTOR_MIN && r_s8_m0 <= MOTOR_MAX &&
                        r_s8_m1 >= MOTOR_MIN && r_s8_m1 <= MOTOR_MAX &&
                        r_s8_m2 >= MOTOR_MIN && r_s8_m2 <= MOTOR_MAX &&
                        r_s8_m3 >= MOTOR_MIN && r_s8_m3 <= MOTOR_MAX))
        else $error("motor drive out of range");

    // The clamped yaw integral never exceeds its limit.
    a_yaw_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (r_s8_yaw <= 20'sd500000 && r_s8_yaw >= -20'sd500000))
        else $error("yaw integral out of range");

    // Any empty stage means the input side must be able to take a word.
    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(&r_vld) |-> o_s_tready)
        else $error("input stalled with room in the pipeline");

    // The yaw mix respects the half-throttle limit.
    a_mix_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[5] |-> (r_s5.g <= $signed({1'b0, r_s5.thr[7:1]}) &&
                      r_s5.g >= -$signed({1'b0, r_s5.thr[7:1]})))
        else $error("yaw mix beyond throttle limit");

    // A word that was accepted shows up at the first stage next cycle.
    a_take_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> r_vld[1])
        else $error("accepted word lost at pipeline entry");
`endif

endmodule

`default_nettype wire

@@ bench/tb_quad_rate_loop_motor_mixer_unit.sv @@
// Self-checking testbench for the quad rate loop motor mixer: a predictor checks every output word.
`default_nettype none

module tb_quad_rate_loop_motor_mixer_unit;
    import qrmm_pkg::*;

    // Control law constants, kept as signed 64-bit values for the predictor.
    localparam longint YAW_CLAMP    = 500000;
    localparam longint TERM_CLAMP   = 30000;
    localparam longint DRIVE_MAX    = 160;
    localparam longint DRIVE_MIN    = 20;
    localparam longint THROTTLE_CAP = 135;
    localparam longint EXPO_DIV     = 512;
    localparam longint BOUND_DIV    = 64;
    localparam longint STICK_GAIN   = 6;

    // Cycles without any handshake before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 2000;

    // One control tick as it enters the block.
    typedef struct {
        logic signed [9:0]  yaw_stick;
        logic signed [13:0] pitch_stick;
        logic signed [13:0] roll_stick;
        logic        [7:0]  throttle;
        logic signed [24:0] pitch_angle;
        logic signed [24:0] roll_angle;
        logic signed [24:0] yaw_angle;
        logic signed [15:0] pitch_rate;
        logic signed [15:0] roll_rate;
        logic signed [15:0] yaw_rate;
    } t_tick;

    // Shapes of random ticks.
    typedef enum int {
        TICK_FLIGHT,
        TICK_FULL,
        TICK_EDGE
    } t_flavor;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic [IN_W-1:0]       i_s_tdata  = '0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [OUT_W-1:0]      o_m_tdata;
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b1;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // Local copy of the configuration registers.
    logic [15:0] angle_gain    = ANGLE_GAIN_RST;
    logic [15:0] rate_gain     = RATE_GAIN_RST;
    logic [15:0] yaw_rate_gain = YAW_RATE_GAIN_RST;
    logic [7:0]  stab_factor   = STABILITY_RST;

    // Expected output words, oldest first.
    logic [OUT_W-1:0] drive_q [$];
    logic [OUT_W-1:0] want_word;

    int mismatch_count = 0;
    int stall_cycles   = 0;
    int ready_hold     = 0;
    bit idle_on        = 1'b1;

    quad_rate_loop_motor_mixer_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tdata  (i_s_tdata),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        begin
            if (v > hi) begin
                return hi;
            end
            if (v < lo) begin
                return lo;
            end
            return v;
        end
    endfunction

    function automatic longint mag(input longint v);
        begin
            return (v < 0) ? -v : v;
        end
    endfunction

    // Predict the output word of one tick under the current gains.
    function automatic logic [OUT_W-1:0] mix_motors(input t_tick tk);
        longint ys, ps, rs, thr, pa, ra, ya, pr, rr, yr, ka, kr, ky, st;
        longint setp, yaw, tp, tr, ty, t, g, bound, dp, dr;
        longint m [4];
        logic [OUT_W-1:0] w;
        begin
            ys  = tk.yaw_stick;
            ps  = tk.pitch_stick;
            rs  = tk.roll_stick;
            thr = tk.throttle;
            pa  = tk.pitch_angle;
            ra  = tk.roll_angle;
            ya  = tk.yaw_angle;
            pr  = tk.pitch_rate;
            rr  = tk.roll_rate;
            yr  = tk.yaw_rate;
            ka  = angle_gain;
            kr  = rate_gain;
            ky  = yaw_rate_gain;
            st  = stab_factor;

            // Expo-shaped yaw command, then the clamped yaw integral.
            setp = (STICK_GAIN * (ys * mag(ys))) / EXPO_DIV;
            setp = setp + (STICK_GAIN * ys) / 4;
            yaw  = clip(ya - setp, -YAW_CLAMP, YAW_CLAMP);

            // Angle plus rate terms, truncated once toward zero and saturated.
            tp = clip((pa * ka + pr * kr * 256) / 16777216, -TERM_CLAMP, TERM_CLAMP);
            tr = clip((ra * ka + rr * kr * 256) / 16777216, -TERM_CLAMP, TERM_CLAMP);
            ty = clip((yr * ky * 1024 + yaw * ka) / 67108864, -TERM_CLAMP, TERM_CLAMP);

            // Yaw mix is bounded by the throttle and cut at low throttle.
            t = (thr > THROTTLE_CAP) ? THROTTLE_CAP : thr;
            g = clip(ty - setp, -(t / 2), t / 2);
            g = clip(g, -(DRIVE_MAX - t), DRIVE_MAX - t);
            if (t < DRIVE_MIN) begin
                g = 0;
            end

            // Pitch and roll corrections under the stability-scaled bound.
            bound = (st * (t + mag(g) / 2)) / BOUND_DIV;
            dp = clip(tp - ps, -bound, bound);
            dr = clip(tr - rs, -bound, bound);

            m[0] = t + dp - g - dr;
            m[1] = t + dp + g + dr;
            m[2] = t - dp + g - dr;
            m[3] = t - dp - g + dr;

            w = '0;
            for (int k = 0; k < 4; k++) begin
                w[8*k +: 8] = clip(m[k], DRIVE_MIN, DRIVE_MAX);
            end
            w[51:32] = yaw[19:0];
            w[64:52] = setp[12:0];
            return w;
        end
    endfunction

    // A field value at one of its extremes, a corner near zero, or anything.
    function automatic logic [31:0] edge_bits(input int w);
        begin
            case ($urandom_range(0, 5))
                0: return 32'd1 << (w - 1);
                1: return (32'd1 << (w - 1)) - 32'd1;
                2: return 32'd0;
                3: return '1;
                4: return 32'd1;
                default: return $urandom;
            endcase
        end
    endfunction

    function automatic t_tick random_tick(input t_flavor fl);
        t_tick tk;
        begin
            case (fl)
                TICK_FULL: begin
                    tk.yaw_stick   = $urandom;
                    tk.pitch_stick = $urandom;
                    tk.roll_stick  = $urandom;
                    tk.throttle    = $urandom;
                    tk.pitch_angle = $urandom;
                    tk.roll_angle  = $urandom;
                    tk.yaw_angle   = $urandom;
                    tk.pitch_rate  = $urandom;
                    tk.roll_rate   = $urandom;
                    tk.yaw_rate    = $urandom;
                end
                TICK_EDGE: begin
                    tk.yaw_stick   = edge_bits(10);
                    tk.pitch_stick = edge_bits(14);
                    tk.roll_stick  = edge_bits(14);
                    tk.throttle    = edge_bits(8);
                    tk.pitch_angle = edge_bits(25);
                    tk.roll_angle  = edge_bits(25);
                    tk.yaw_angle   = edge_bits(25);
                    tk.pitch_rate  = edge_bits(16);
                    tk.roll_rate   = edge_bits(16);
                    tk.yaw_rate    = edge_bits(16);
                end
                default: begin
                    // Values a hovering craft would see, so the clamps act one at a time.
                    tk.yaw_stick   = int'($urandom_range(0, 1023)) - 512;
                    tk.pitch_stick = int'($urandom_range(0, 800)) - 400;
                    tk.roll_stick  = int'($urandom_range(0, 800)) - 400;
                    tk.throttle    = $urandom_range(10, 150);
                    tk.pitch_angle = int'($urandom_range(0, 4000000)) - 2000000;
                    tk.roll_angle  = int'($urandom_range(0, 4000000)) - 2000000;
                    tk.yaw_angle   = int'($urandom_range(0, 1200000)) - 600000;
                    tk.pitch_rate  = int'($urandom_range(0, 8000)) - 4000;
                    tk.roll_rate   = int'($urandom_range(0, 8000)) - 4000;
                    tk.yaw_rate    = int'($urandom_range(0, 8000)) - 4000;
                end
            endcase
            return tk;
        end
    endfunction

    function automatic t_flavor pick_flavor();
        int r;
        begin
            r = $urandom_range(0, 9);
            if (r < 7) begin
                return TICK_FLIGHT;
            end
            return (r < 9) ? TICK_FULL : TICK_EDGE;
        end
    endfunction

    // Offer one tick, wait for the handshake, then maybe leave a gap.
    task automatic send_word(input t_tick tk);
        logic [IN_W-1:0] d;
        int gap;
        begin
            d          = '0;
            d[9:0]     = tk.yaw_stick;
            d[23:10]   = tk.pitch_stick;
            d[37:24]   = tk.roll_stick;
            d[45:38]   = tk.throttle;
            d[70:46]   = tk.pitch_angle;
            d[95:71]   = tk.roll_angle;
            d[120:96]  = tk.yaw_angle;
            d[136:121] = tk.pitch_rate;
            d[152:137] = tk.roll_rate;
            d[168:153] = tk.yaw_rate;
            i_s_tdata  <= d;
            i_s_tvalid <= 1'b1;
            do @(posedge i_clk); while (!o_s_tready);
            drive_q.push_back(mix_motors(tk));
            if (idle_on && $urandom_range(0, 7) == 0) begin
                gap = $urandom_range(1, 14);
                i_s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Stop sending and let every word in flight come out.
    task automatic settle();
        begin
            i_s_tvalid <= 1'b0;
            while (drive_q.size() != 0) @(posedge i_clk);
            repeat (NSTAGE) @(posedge i_clk);
        end
    endtask

    // Write all four registers while the pipeline is empty.
    task automatic apply_settings(input logic [15:0] ka, input logic [15:0] kr,
                                  input logic [15:0] ky, input logic [7:0] st);
        t_cfg_idx              idx_list [4];
        logic [CFG_DATA_W-1:0] val_list [4];
        begin
            idx_list = '{CFG_ANGLE_GAIN, CFG_RATE_GAIN, CFG_YAW_RATE_GAIN, CFG_STABILITY};
            val_list = '{ka, kr, ky, {8'd0, st}};
            settle();
            for (int k = 0; k < 4; k++) begin
                i_cfg_we   <= 1'b1;
                i_cfg_idx  <= idx_list[k];
                i_cfg_data <= val_list[k];
                @(posedge i_clk);
            end
            i_cfg_we      <= 1'b0;
            angle_gain    = ka;
            rate_gain     = kr;
            yaw_rate_gain = ky;
            stab_factor   = st;
        end
    endtask

    function automatic logic [15:0] random_gain();
        begin
            case ($urandom_range(0, 5))
                0: return 16'h0000;
                1: return 16'hFFFF;
                default: return $urandom;
            endcase
        end
    endfunction

    task automatic check_field(input string name, input logic [19:0] want,
                               input logic [19:0] got);
        begin
            if (want !== got) begin
                mismatch_count++;
                $display("%0t: %s mismatch, expected 0x%h, actual 0x%h", $time, name, want, got);
            end
        end
    endtask

    // Extremes of every field and each clamp of the control law, reset gains.
    task automatic test_directed_cases();
        t_tick tk;
        int thr_cases [6];
        begin
            thr_cases = '{0, 19, 20, 135, 136, 255};
            tk = '{default: '0};
            send_word(tk);

            // Expo curve at both stick ends and around zero.
            tk.throttle  = 8'd80;
            tk.yaw_stick = 10'h200;
            send_word(tk);
            tk.yaw_stick = 10'h1FF;
            send_word(tk);
            tk.yaw_stick = 10'h001;
            send_word(tk);
            tk.yaw_stick = 10'h3FF;
            send_word(tk);

            // Throttle cut-off, the throttle cap and values above it.
            tk.yaw_stick = 10'sd300;
            tk.yaw_rate  = 16'h7FFF;
            foreach (thr_cases[k]) begin
                tk.throttle = thr_cases[k];
                send_word(tk);
            end

            tk = '{default: '0};
            tk.throttle    = 8'd100;
            tk.pitch_angle = 25'hFFFFFF;
            tk.roll_angle  = 25'h1000000;
            send_word(tk);
            tk.pitch_angle = 25'h1000000;
            tk.roll_angle  = 25'hFFFFFF;
            send_word(tk);

            // Yaw integral clamped at both ends.
            tk.yaw_angle = 25'hFFFFFF;
            send_word(tk);
            tk.yaw_angle = 25'h1000000;
            send_word(tk);

            tk = '{default: '0};
            tk.throttle   = 8'd60;
            tk.pitch_rate = 16'h7FFF;
            tk.roll_rate  = 16'h8000;
            send_word(tk);
            tk.pitch_rate = 16'h8000;
            tk.roll_rate  = 16'h7FFF;
            send_word(tk);
            tk.yaw_rate = 16'h7FFF;
            send_word(tk);
            tk.yaw_rate = 16'h8000;
            send_word(tk);

            // Large stick commands against the correction bound.
            tk = '{default: '0};
            tk.throttle    = 8'd120;
            tk.pitch_stick = 14'h1FFF;
            tk.roll_stick  = 14'h2000;
            send_word(tk);
            tk.pitch_stick = 14'h2000;
            tk.roll_stick  = 14'h1FFF;
            send_word(tk);

            tk = '{10'h1FF, 14'h1FFF, 14'h1FFF, 8'hFF, 25'hFFFFFF, 25'hFFFFFF, 25'hFFFFFF,
                   16'h7FFF, 16'h7FFF, 16'h7FFF};
            send_word(tk);
            tk = '{10'h200, 14'h2000, 14'h2000, 8'h80, 25'h1000000, 25'h1000000,
                   25'h1000000, 16'h8000, 16'h8000, 16'h8000};
            send_word(tk);
        end
    endtask

    // Largest and zero gains, so the term saturation and the zero paths show.
    task automatic test_gain_extremes();
        begin
            apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
            for (int i = 0; i < 60; i++) begin
                send_word(random_tick(($urandom_range(0, 1) == 0) ? TICK_EDGE : TICK_FULL));
            end
            apply_settings(16'h0000, 16'h0000, 16'h0000, 8'h00);
            for (int i = 0; i < 40; i++) begin
                send_word(random_tick(pick_flavor()));
            end
        end
    endtask

    // Random gain settings, each with a batch of mixed ticks.
    task automatic test_gain_sweep();
        begin
            for (int s = 0; s < 4; s++) begin
                apply_settings(random_gain(), random_gain(), random_gain(), $urandom);
                for (int i = 0; i < 150; i++) begin
                    send_word(random_tick(pick_flavor()));
                end
            end
        end
    endtask

    // Default gains with mostly flight-like ticks; idling switches on and off by stretch.
    task automatic test_flight_mix();
        begin
            apply_settings(ANGLE_GAIN_RST, RATE_GAIN_RST, YAW_RATE_GAIN_RST, STABILITY_RST);
            for (int i = 0; i < 1000; i++) begin
                if (i % 100 == 0) begin
                    idle_on = ($urandom_range(0, 3) != 0);
                end
                send_word(random_tick(pick_flavor()));
            end
        end
    endtask

    // Back-to-back words at full rate with no idling on either side.
    task automatic test_steady_stream();
        begin
            apply_settings(random_gain(), random_gain(), random_gain(), $urandom);
            idle_on = 1'b0;
            for (int i = 0; i < 200; i++) begin
                send_word(random_tick(pick_flavor()));
            end
        end
    endtask

    // Output side: check each accepted word, then decide on a stall.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (drive_q.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected word, expected none, actual 0x%h", $time, o_m_tdata);
            end else begin
                want_word = drive_q.pop_front();
                check_field("motor_front",   want_word[7:0],   o_m_tdata[7:0]);
                check_field("motor_second",  want_word[15:8],  o_m_tdata[15:8]);
                check_field("motor_third",   want_word[23:16], o_m_tdata[23:16]);
                check_field("motor_fourth",  want_word[31:24], o_m_tdata[31:24]);
                check_field("yaw_angle_out", want_word[51:32], o_m_tdata[51:32]);
                check_field("yaw_setpoint",  want_word[64:52], o_m_tdata[64:52]);
            end
        end
        if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
            i_m_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            ready_hold <= $urandom_range(0, 13);
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // Watchdog on cycles where neither side moves a word.
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_quad_rate_loop_motor_mixer_unit: errors");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_cases();
        test_gain_extremes();
        test_gain_sweep();
        test_flight_mix();
        test_steady_stream();

        settle();
        repeat (NSTAGE) @(posedge i_clk);
        if (drive_q.size() != 0) begin
            mismatch_count++;
            $display("%0t: words missing, expected %0d more, actual 0", $time, drive_q.size());
        end
        if (mismatch_count == 0) begin
            $display("tb_quad_rate_loop_motor_mixer_unit: clean");
        end else begin
            $display("tb_quad_rate_loop_motor_mixer_unit: errors");
        end
        $finish;
    end

endmodule

`default_nettype wire
